@@ src/smix_pkg.sv @@
`timescale 1ns / 1ps

package smix_pkg;

  // Field widths fixed by the item formats
  localparam int ADDR_W   = 17;
  localparam int SUM_W    = ADDR_W + 1;
  localparam int BYTE_W   = 8;
  localparam int VOL_W    = 7;
  localparam int PITCH_W  = 20;
  localparam int FRAC_SRC = 16;
  localparam int FRAC_MAX = 24;
  localparam int STEP_PAD = FRAC_MAX - FRAC_SRC;

  // Action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_SETUP  = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;

  localparam logic [VOL_W-1:0]  VOL_FULL = 7'd64;
  localparam logic [ADDR_W-1:0] LOOP_MIN = 17'd2;

  localparam logic signed [15:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [15:0] OUT_MIN = 16'sh8000;

  typedef struct packed {
    logic [1:0]               action;
    logic [ADDR_W-1:0]        address;
    logic signed [BYTE_W-1:0] sample_byte;
    logic [1:0]               voice;
    logic [ADDR_W-1:0]        sample_length;
    logic [ADDR_W-1:0]        loop_begin;
    logic [ADDR_W-1:0]        loop_length;
    logic [PITCH_W-1:0]       pitch_step;
    logic [VOL_W-1:0]         volume;
    logic                     retrigger;
    logic [ADDR_W-1:0]        start_offset;
  } in_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic [3:0]         voices_playing;
  } out_t;

endpackage

@@ src/smix_ram.sv @@
`timescale 1ns / 1ps

module smix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/smix_modu.sv @@
`timescale 1ns / 1ps

// Restoring remainder unit: one numerator bit per cycle.
module smix_modu #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next bit, subtract when it fits
      rem_d = (trial >= {1'b0, den_q}) ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_d = num_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ src/four_voice_sample_mixer_top.sv @@
`timescale 1ns / 1ps

// Four-voice 8-bit sample mixer.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one command per transfer:
// write a sample byte, set up a voice, or render one output sample. Only a render
// produces a transfer on the output channel (out_valid_o / out_ready_i / out_data_o).
// cfg_we_i / cfg_wdata_i write the player enable; write it only while the block is idle.
// Work is done one command at a time by a sequencer around one shared datapath, one
// sample memory port and one bit-serial remainder unit for loop wrap.
// A voice set-up is taken in the idle state; a byte write reduces the address, then writes.
// A render visits each voice in turn: a silent voice is skipped, a playing one reads
// two bytes (one when it is on its last byte and not looped), blends, scales by volume
// and accumulates, and a looped voice that wraps waits for the remainder unit.
// A memory size that is not a power of two adds a wait state to every address reduction.
// Reset clears all voice state and the enable; sample memory is not cleared.
// A finished result sits in the output register; the next command is still accepted,
// and a render only stalls at its last step while an earlier result is not taken.
module four_voice_sample_mixer_top #(
  parameter int VOICES           = 4,
  parameter int SAMPLE_MEM_BYTES = 131072,
  parameter int FRAC_BITS        = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  smix_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output smix_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  import smix_pkg::*;

  // Derived widths
  localparam int POS_W    = ADDR_W + FRAC_BITS;
  localparam int STEP_W   = 4 + FRAC_BITS;
  localparam int MEM_AW   = $clog2(SAMPLE_MEM_BYTES);
  localparam bit MEM_POW2 = (SAMPLE_MEM_BYTES & (SAMPLE_MEM_BYTES - 1)) == 0;
  localparam int WIDE_W   = (MEM_AW > SUM_W) ? MEM_AW : SUM_W;
  localparam int MEM_DW   = $clog2(SAMPLE_MEM_BYTES + 1);
  localparam int DEN_W    = (MEM_DW > ADDR_W) ? MEM_DW : ADDR_W;
  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int PROD_W   = FRAC_BITS + 10;
  localparam int Y_W      = FRAC_BITS + 17;
  localparam int ACC_W    = FRAC_BITS + 16 + $clog2(VOICES);
  localparam int STEP_TW  = PITCH_W + STEP_PAD;
  localparam int RED_W    = SUM_W + DEN_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(OUT_MIN);

  // Memory size reciprocal scaled by 2^SUM_W; the quotient estimate is at most one low
  localparam logic [SUM_W-1:0] MEM_RECIP  = SUM_W'((1 << SUM_W) / SAMPLE_MEM_BYTES);
  localparam logic [RED_W-1:0] MEM_SIZE_R = RED_W'(SAMPLE_MEM_BYTES);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ASTART = 4'd1;
  localparam logic [3:0] S_AWAIT  = 4'd2;
  localparam logic [3:0] S_WRITE  = 4'd3;
  localparam logic [3:0] S_VOICE  = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_DATA   = 4'd6;
  localparam logic [3:0] S_MUL1   = 4'd7;
  localparam logic [3:0] S_MUL2   = 4'd8;
  localparam logic [3:0] S_MUL3   = 4'd9;
  localparam logic [3:0] S_ACC    = 4'd10;
  localparam logic [3:0] S_LWAIT  = 4'd11;
  localparam logic [3:0] S_NEXT   = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  // Per-voice state, read only at the voice under render
  logic [ADDR_W-1:0] base_q [VOICES];
  logic [ADDR_W-1:0] len_q  [VOICES];
  logic [ADDR_W-1:0] lb_q   [VOICES];
  logic [ADDR_W-1:0] ll_q   [VOICES];
  logic [POS_W-1:0]  pos_q  [VOICES];
  logic [STEP_W-1:0] step_q [VOICES];
  logic [VOL_W-1:0]  vol_q  [VOICES];
  logic [VOICES-1:0] active_q;
  logic              enabled_q;

  // Sequencer and datapath registers
  logic [3:0]               state_q, state_d;
  logic [VIDX_W-1:0]        voice_q, voice_d;
  logic                     wr_mode_q, wr_mode_d;
  logic                     sel_b_q, sel_b_d;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [SUM_W-1:0]         quot_q, quot_d;
  logic [MEM_AW-1:0]        addr_q, addr_d;
  logic [BYTE_W-1:0]        byte_q, byte_d;
  logic signed [BYTE_W-1:0] a_q, a_d;
  logic signed [BYTE_W-1:0] b_q, b_d;
  logic [ADDR_W-1:0]        ip_q, ip_d;
  logic [FRAC_BITS-1:0]     frac_q, frac_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PROD_W-1:0] x_q, x_d;
  logic signed [Y_W-1:0]    y_q, y_d;
  logic [POS_W-1:0]         posn_q, posn_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     out_valid_q, out_valid_d;
  out_t                     out_q, out_d;

  // Current voice view
  logic [ADDR_W-1:0] cur_base, cur_len, cur_lb, cur_ll, cur_ip;
  logic [POS_W-1:0]  cur_pos;
  logic [STEP_W-1:0] cur_step;
  logic [VOL_W-1:0]  cur_vol;
  logic              cur_looped;
  logic [SUM_W-1:0]  cur_loop_end;
  logic [ADDR_W-1:0] posn_int;
  logic [POS_W:0]    pos_sum;

  // Update strobes
  logic              accept;
  logic              setup_we;
  logic [2:0]        vsel_wide;
  logic [VIDX_W-1:0] vsel_idx;
  logic              pos_we;
  logic [POS_W-1:0]  pos_wdata;
  logic              act_clr;

  // Set-up values
  logic [SUM_W-1:0]   set_lbll;
  logic [ADDR_W-1:0]  set_ll;
  logic [STEP_TW-1:0] set_step_wide;
  logic [VOL_W-1:0]   set_vol;
  logic [ADDR_W-1:0]  set_start;

  // Memory, address reduction and remainder unit
  logic               ram_we;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [WIDE_W-1:0]  sum_wide;
  logic [2*SUM_W-1:0] quot_prod;
  logic [RED_W-1:0]   red_diff;
  logic [RED_W-1:0]   red_addr;
  logic               wrap_start;
  logic [SUM_W-1:0]   mod_num;
  logic [DEN_W-1:0]   mod_den;
  logic               mod_done;
  logic [DEN_W-1:0]   mod_rem;

  // Output rounding
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] rnd_sh;
  logic [3:0]              playing;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign cur_base     = base_q[voice_q];
  assign cur_len      = len_q[voice_q];
  assign cur_lb       = lb_q[voice_q];
  assign cur_ll       = ll_q[voice_q];
  assign cur_pos      = pos_q[voice_q];
  assign cur_step     = step_q[voice_q];
  assign cur_vol      = vol_q[voice_q];
  assign cur_ip       = cur_pos[POS_W-1:FRAC_BITS];
  assign cur_looped   = cur_ll > LOOP_MIN;
  assign cur_loop_end = {1'b0, cur_lb} + {1'b0, cur_ll};
  assign posn_int     = posn_q[POS_W-1:FRAC_BITS];
  assign pos_sum      = {1'b0, cur_pos} + (POS_W + 1)'(cur_step);
  assign sum_wide     = WIDE_W'(sum_q);

  // Address reduction for a memory size that is not a power of two:
  // estimate the quotient, subtract it back, fix up with one compare and subtract
  assign quot_prod = (2 * SUM_W)'(sum_q) * (2 * SUM_W)'(MEM_RECIP);
  assign red_diff  = RED_W'(sum_q) - RED_W'(quot_q) * MEM_SIZE_R;
  assign red_addr  = (red_diff >= MEM_SIZE_R) ? red_diff - MEM_SIZE_R : red_diff;

  // Voice set-up: clamp loop and start into the sample, saturate volume, rescale the step
  assign vsel_wide     = {1'b0, in_data_i.voice};
  assign vsel_idx      = vsel_wide[VIDX_W-1:0];
  assign setup_we      = accept && (in_data_i.action == ACT_SETUP)
                         && ({1'b0, vsel_wide} < 4'(VOICES));
  assign set_lbll      = {1'b0, in_data_i.loop_begin} + {1'b0, in_data_i.loop_length};
  assign set_step_wide = {in_data_i.pitch_step, {STEP_PAD{1'b0}}} >> (FRAC_MAX - FRAC_BITS);
  assign set_vol       = (in_data_i.volume > VOL_FULL) ? VOL_FULL : in_data_i.volume;
  assign set_start     = (in_data_i.start_offset < in_data_i.sample_length)
                         ? in_data_i.start_offset : in_data_i.sample_length;

  always_comb begin
    set_ll = in_data_i.loop_length;
    if (set_lbll > {1'b0, in_data_i.sample_length}) begin
      set_ll = (in_data_i.loop_begin > in_data_i.sample_length)
               ? '0 : in_data_i.sample_length - in_data_i.loop_begin;
    end
  end

  // Remainder unit serves the loop wrap
  assign mod_num = {1'b0, posn_int - cur_lb};
  assign mod_den = DEN_W'(cur_ll);

  assign rnd    = acc_q + RND_HALF;
  assign rnd_sh = rnd >>> FRAC_BITS;

  for (genvar g = 0; g < 4; g++) begin : g_playing
    if (g < VOICES) begin : g_on
      assign playing[g] = active_q[g];
    end else begin : g_off
      assign playing[g] = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    voice_d     = voice_q;
    wr_mode_d   = wr_mode_q;
    sel_b_d     = sel_b_q;
    sum_d       = sum_q;
    quot_d      = quot_q;
    addr_d      = addr_q;
    byte_d      = byte_q;
    a_d         = a_q;
    b_d         = b_q;
    ip_d        = ip_q;
    frac_d      = frac_q;
    prod_d      = prod_q;
    x_d         = x_q;
    y_d         = y_q;
    posn_d      = posn_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wrap_start  = 1'b0;
    ram_we      = 1'b0;
    pos_we      = 1'b0;
    pos_wdata   = posn_q;
    act_clr     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.action)
            ACT_WRITE: begin
              sum_d     = {1'b0, in_data_i.address};
              byte_d    = in_data_i.sample_byte;
              wr_mode_d = 1'b1;
              state_d   = S_ASTART;
            end
            ACT_RENDER: begin
              acc_d     = '0;
              voice_d   = '0;
              wr_mode_d = 1'b0;
              // disabled player: zero result, no voice state touched
              state_d   = enabled_q ? S_VOICE : S_FIN;
            end
            default: ;
          endcase
        end
      end

      S_VOICE: begin
        if (!active_q[voice_q]) begin
          state_d = S_NEXT;
        end else if (cur_ip >= cur_len) begin
          // past its end: stop and contribute nothing
          act_clr = 1'b1;
          state_d = S_NEXT;
        end else begin
          ip_d    = cur_ip;
          frac_d  = cur_pos[FRAC_BITS-1:0];
          sum_d   = {1'b0, cur_base} + {1'b0, cur_ip};
          sel_b_d = 1'b0;
          state_d = S_ASTART;
        end
      end

      S_ASTART: begin
        if (MEM_POW2) begin
          addr_d  = sum_wide[MEM_AW-1:0];
          state_d = wr_mode_q ? S_WRITE : S_READ;
        end else begin
          quot_d  = quot_prod[2*SUM_W-1:SUM_W];
          state_d = S_AWAIT;
        end
      end

      S_AWAIT: begin
        addr_d  = red_addr[MEM_AW-1:0];
        state_d = wr_mode_q ? S_WRITE : S_READ;
      end

      S_WRITE: begin
        ram_we  = 1'b1;
        state_d = S_IDLE;
      end

      S_READ: begin
        state_d = S_DATA;
      end

      S_DATA: begin
        if (!sel_b_q) begin
          a_d = ram_rdata;
          if (({1'b0, ip_q} + SUM_W'(1)) < {1'b0, cur_len}) begin
            sum_d   = {1'b0, cur_base} + {1'b0, ip_q} + SUM_W'(1);
            sel_b_d = 1'b1;
            state_d = S_ASTART;
          end else if (cur_looped) begin
            // last byte of a looped sample: blend toward the loop start
            sum_d   = {1'b0, cur_base} + {1'b0, cur_lb};
            sel_b_d = 1'b1;
            state_d = S_ASTART;
          end else begin
            b_d     = ram_rdata;
            state_d = S_MUL1;
          end
        end else begin
          b_d     = ram_rdata;
          state_d = S_MUL1;
        end
      end

      S_MUL1: begin
        prod_d  = $signed(PROD_W'(b_q) - PROD_W'(a_q))
                  * $signed(PROD_W'({1'b0, frac_q}));
        state_d = S_MUL2;
      end

      S_MUL2: begin
        x_d     = (PROD_W'(a_q) <<< FRAC_BITS) + prod_q;
        state_d = S_MUL3;
      end

      S_MUL3: begin
        y_d     = Y_W'(x_q) * $signed(Y_W'({1'b0, cur_vol}));
        // advance, holding at the top of the position range
        posn_d  = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
        state_d = S_ACC;
      end

      S_ACC: begin
        acc_d = acc_q + ACC_W'(y_q);
        if (cur_looped) begin
          if ({1'b0, posn_int} >= cur_loop_end) begin
            wrap_start = 1'b1;
            state_d    = S_LWAIT;
          end else begin
            pos_we  = 1'b1;
            state_d = S_NEXT;
          end
        end else begin
          pos_we  = 1'b1;
          act_clr = posn_int >= cur_len;
          state_d = S_NEXT;
        end
      end

      S_LWAIT: begin
        if (mod_done) begin
          pos_we    = 1'b1;
          pos_wdata = {cur_lb + mod_rem[ADDR_W-1:0], posn_q[FRAC_BITS-1:0]};
          state_d   = S_NEXT;
        end
      end

      S_NEXT: begin
        if (voice_q == VIDX_W'(VOICES - 1)) begin
          state_d = S_FIN;
        end else begin
          voice_d = voice_q + VIDX_W'(1);
          state_d = S_VOICE;
        end
      end

      S_FIN: begin
        // hold here while an earlier result still waits for its transfer
        if (!out_valid_q || out_ready_i) begin
          if (rnd_sh > SAT_HI) begin
            out_d.mixed_sample = OUT_MAX;
          end else if (rnd_sh < SAT_LO) begin
            out_d.mixed_sample = OUT_MIN;
          end else begin
            out_d.mixed_sample = rnd_sh[15:0];
          end
          out_d.voices_playing = playing;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      voice_q     <= '0;
      wr_mode_q   <= 1'b0;
      sel_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
      enabled_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      voice_q     <= voice_d;
      wr_mode_q   <= wr_mode_d;
      sel_b_q     <= sel_b_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    quot_q <= quot_d;
    addr_q <= addr_d;
    byte_q <= byte_d;
    a_q    <= a_d;
    b_q    <= b_d;
    ip_q   <= ip_d;
    frac_q <= frac_d;
    prod_q <= prod_d;
    x_q    <= x_d;
    y_q    <= y_d;
    posn_q <= posn_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  // Voice registers: set-up from the input, position and stop from the render
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VOICES; k++) begin
        base_q[k] <= '0;
        len_q[k]  <= '0;
        lb_q[k]   <= '0;
        ll_q[k]   <= '0;
        pos_q[k]  <= '0;
        step_q[k] <= '0;
        vol_q[k]  <= '0;
      end
      active_q <= '0;
    end else begin
      for (int k = 0; k < VOICES; k++) begin
        if (setup_we && (vsel_idx == VIDX_W'(k))) begin
          base_q[k] <= in_data_i.address;
          len_q[k]  <= in_data_i.sample_length;
          lb_q[k]   <= in_data_i.loop_begin;
          ll_q[k]   <= set_ll;
          step_q[k] <= set_step_wide[STEP_W-1:0];
          vol_q[k]  <= set_vol;
          if (in_data_i.retrigger) begin
            pos_q[k]    <= {set_start, {FRAC_BITS{1'b0}}};
            active_q[k] <= in_data_i.sample_length != '0;
          end
        end else begin
          if (pos_we && (voice_q == VIDX_W'(k))) begin
            pos_q[k] <= pos_wdata;
          end
          if (act_clr && (voice_q == VIDX_W'(k))) begin
            active_q[k] <= 1'b0;
          end
        end
      end
    end
  end

  smix_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SAMPLE_MEM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (byte_q),
    .rdata_o (ram_rdata)
  );

  smix_modu #(
    .NUM_W(SUM_W),
    .DEN_W(DEN_W)
  ) u_modu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .num_i   (mod_num),
    .den_i   (mod_den),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // The remainder unit only finishes while the sequencer waits for it
  a_mod_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_LWAIT))
    else $error("remainder finished outside a wait state");

  // A loop wrap lands inside the loop
  a_wrap_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_done && state_q == S_LWAIT) |-> (mod_rem < DEN_W'(cur_ll)))
    else $error("loop wrap remainder not below loop length");

  // A new result only comes from the final render step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside the final render step");

  // The voice index never runs past the last voice
  a_voice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VOICE) |-> (voice_q <= VIDX_W'(VOICES - 1)))
    else $error("voice index out of range");
`endif

endmodule

@@ bench/tb_four_voice_sample_mixer_top.sv @@
`timescale 1ns / 1ps

module tb_four_voice_sample_mixer_top;
  import smix_pkg::*;

  localparam int          MEM_BYTES     = 131072;
  localparam int          FRAC          = 16;
  localparam longint      POS_MAX       = (64'sd1 <<< 33) - 1;
  localparam int unsigned LEN_MAX       = 131070;
  localparam int unsigned ADDR_MAX      = 131071;
  localparam logic [1:0]  ACT_NONE      = 2'd3;   // undefined action, dropped by the block
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          CYCLE_LIMIT   = 1000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic cfg_wdata;

  four_voice_sample_mixer_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Mirror of the mixer state, advanced once per accepted command transfer.
  logic signed [7:0] mem_img [MEM_BYTES];
  bit                mem_set [MEM_BYTES];   // byte written at least once
  longint            v_base [4];
  longint            v_len  [4];
  longint            v_lbeg [4];
  longint            v_llen [4];
  longint            v_pos  [4];
  longint            v_step [4];
  longint            v_vol  [4];
  bit [3:0]          v_on;
  bit                mix_enabled;

  // Predicted output transfers, oldest first.
  out_t mix_expected [$];

  // Sample regions known to be fully written; voices are placed only inside them.
  int unsigned reg_base [$];
  int unsigned reg_len  [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;
  int          mismatch_count;
  int          cycle_count;
  int          hold_left;
  bit          hold_req;

  always #10 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int byte_at(longint base, longint off);
    return int'(mem_img[(base + off) % MEM_BYTES]);
  endfunction

  // Weighted contribution of one playing voice; advance its position.
  function automatic longint voice_tap(int k);
    longint pos, ip, fr, x, lbp, llp;
    int     a, b;
    bit     looped;
    pos    = v_pos[k];
    ip     = pos >>> FRAC;
    fr     = pos & ((64'sd1 <<< FRAC) - 1);
    looped = v_llen[k] > 2;
    // Drop a voice whose position already sits past its end.
    if (ip >= v_len[k]) begin
      v_on[k] = 1'b0;
      return 0;
    end
    a = byte_at(v_base[k], ip);
    if (ip + 1 < v_len[k]) b = byte_at(v_base[k], ip + 1);
    else if (looped)       b = byte_at(v_base[k], v_lbeg[k]);
    else                   b = a;
    x = longint'(a) * (64'sd1 <<< FRAC) + longint'(b - a) * fr;
    x = x * v_vol[k];
    pos = pos + v_step[k];
    if (pos > POS_MAX) pos = POS_MAX;
    if (looped) begin
      lbp = v_lbeg[k] <<< FRAC;
      llp = v_llen[k] <<< FRAC;
      if (pos >= lbp + llp) pos = lbp + (pos - lbp) % llp;
    end else if (pos >= (v_len[k] <<< FRAC)) begin
      v_on[k] = 1'b0;
    end
    v_pos[k] = pos;
    return x;
  endfunction

  function automatic out_t mix_render();
    longint acc, r;
    out_t   o;
    acc = 0;
    r   = 0;
    if (mix_enabled) begin
      for (int k = 0; k < 4; k++)
        if (v_on[k]) acc += voice_tap(k);
      // Round to nearest, ties up, then clamp to Q15.
      r = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (r > longint'(OUT_MAX)) r = longint'(OUT_MAX);
      if (r < longint'(OUT_MIN)) r = longint'(OUT_MIN);
    end
    o.mixed_sample   = r[15:0];
    o.voices_playing = v_on;
    return o;
  endfunction

  function automatic void mix_apply(in_t c);
    longint len, lb, ll, start;
    int     v;
    case (c.action)
      ACT_WRITE: begin
        mem_img[c.address] = c.sample_byte;
        mem_set[c.address] = 1'b1;
      end
      ACT_SETUP: begin
        v   = c.voice;
        len = c.sample_length;
        lb  = c.loop_begin;
        ll  = c.loop_length;
        // Trim a loop that runs past the sample end.
        if (lb + ll > len) ll = (lb > len) ? 0 : len - lb;
        v_base[v] = c.address;
        v_len[v]  = len;
        v_lbeg[v] = lb;
        v_llen[v] = ll;
        v_step[v] = c.pitch_step;
        v_vol[v]  = (c.volume > VOL_FULL) ? longint'(VOL_FULL) : longint'(c.volume);
        if (c.retrigger) begin
          start    = c.start_offset;
          v_pos[v] = ((start < len) ? start : len) <<< FRAC;
          v_on[v]  = len > 0;
        end
      end
      ACT_RENDER: mix_expected.push_back(mix_render());
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic bit reads_written(longint base, longint len);
    for (longint i = 0; i < len; i++)
      if (!mem_set[(base + i) % MEM_BYTES]) return 1'b0;
    return 1'b1;
  endfunction

  // Never let a voice play over bytes that were never written: park it past its end.
  function automatic in_t guard_setup(in_t c);
    longint len;
    bit     plays;
    len   = c.sample_length;
    plays = c.retrigger ? (c.start_offset < len) : v_on[c.voice];
    if (c.action == ACT_SETUP && plays && !reads_written(c.address, len)) begin
      c.retrigger    = 1'b1;
      c.start_offset = $urandom_range(ADDR_MAX, len);
    end
    return c;
  endfunction

  function automatic in_t noise_fields();
    in_t c;
    c.action        = $urandom_range(3);
    c.address       = $urandom;
    c.sample_byte   = $urandom;
    c.voice         = $urandom;
    c.sample_length = $urandom_range(LEN_MAX);
    c.loop_begin    = $urandom_range(LEN_MAX);
    c.loop_length   = $urandom_range(LEN_MAX);
    c.pitch_step    = $urandom;
    c.volume        = $urandom;
    c.retrigger     = $urandom;
    c.start_offset  = $urandom;
    return c;
  endfunction

  function automatic in_t render_cmd();
    in_t c;
    c        = noise_fields();
    c.action = ACT_RENDER;
    return c;
  endfunction

  function automatic in_t make_setup(int unsigned voice, int unsigned base, int unsigned len,
                                     int unsigned lb, int unsigned ll, int unsigned step,
                                     int unsigned vol, bit retrig, int unsigned start);
    in_t c;
    c               = noise_fields();
    c.action        = ACT_SETUP;
    c.voice         = voice;
    c.address       = base;
    c.sample_length = len;
    c.loop_begin    = lb;
    c.loop_length   = ll;
    c.pitch_step    = step;
    c.volume        = vol;
    c.retrigger     = retrig;
    c.start_offset  = start;
    return c;
  endfunction

  // Well-formed voice set-up placed inside a written region, random content.
  function automatic in_t shaped_setup();
    int unsigned idx, off, room, len, step, vol;
    idx  = $urandom_range(reg_base.size() - 1);
    off  = $urandom_range(reg_len[idx] - 1);
    room = reg_len[idx] - off;
    len  = ($urandom_range(9) == 0) ? 0 : $urandom_range(room, 1);
    case ($urandom_range(3))
      0:       step = $urandom_range(32'hFFFF);
      1, 2:    step = $urandom_range(32'h3FFFF);
      default: step = $urandom_range(32'hFFFFF);
    endcase
    vol = ($urandom_range(7) == 0) ? $urandom_range(127, 65) : $urandom_range(64);
    return make_setup($urandom_range(3), reg_base[idx] + off, len, $urandom_range(len + 1),
                      $urandom_range(len + 1), step, vol, $urandom_range(9) != 0,
                      $urandom_range(len + 2));
  endfunction

  // One command transfer. Idle first at random; keep valid high across back-to-back items.
  task automatic send_cmd(input in_t c);
    c = guard_setup(c);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_apply(c);
    if (c.action != ACT_NONE) items_sent++;
  endtask

  task automatic write_bytes(input int unsigned base, input int unsigned n);
    in_t         c;
    int unsigned roll;
    for (int unsigned i = 0; i < n; i++) begin
      c         = noise_fields();
      c.action  = ACT_WRITE;
      c.address = base + i;
      roll      = $urandom_range(9);
      if (roll == 0)      c.sample_byte = 8'sh7f;
      else if (roll == 1) c.sample_byte = 8'sh80;
      send_cmd(c);
    end
    reg_base.push_back(base % MEM_BYTES);
    reg_len.push_back(n);
  endtask

  // Drop valid and hold until every predicted result has been taken.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mix_expected.size() != 0) @(posedge clk);
  endtask

  // Write the enable only while idle: drain, let trailing writes finish, then write.
  task automatic set_player_enable(input bit en);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mix_enabled = en;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each output transfer against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mix_expected.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing predicted", out_data));
      end else begin
        want = mix_expected.pop_front();
        if (out_data.mixed_sample !== want.mixed_sample)
          report_mismatch($sformatf("mixed_sample %0d, predicted %0d",
                                    out_data.mixed_sample, want.mixed_sample));
        if (out_data.voices_playing !== want.voices_playing)
          report_mismatch($sformatf("voices_playing %b, predicted %b",
                                    out_data.voices_playing, want.voices_playing));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Memory wrap at the top address, byte extremes, volume clamp, loop trimming,
  // start clamp, maximum length, zero step, zero volume, dropped action.
  task automatic test_wrap_and_extremes();
    int unsigned bytes [6] = '{127, 128, 255, 0, 100, 156};
    in_t         c;
    // Six bytes straddling the end of memory: 131068..131071, 0, 1.
    for (int i = 0; i < 6; i++) begin
      c             = noise_fields();
      c.action      = ACT_WRITE;
      c.address     = 131068 + i;
      c.sample_byte = bytes[i];
      send_cmd(c);
    end
    reg_base.push_back(131068);
    reg_len.push_back(6);
    // Looped voice, loop ends exactly at the sample end.
    send_cmd(make_setup(0, 131068, 6, 2, 4, 32'h18000, 64, 1'b1, 0));
    // Unlooped, largest step, volume above full scale.
    send_cmd(make_setup(1, 131068, 6, 0, 0, 32'hFFFFF, 127, 1'b1, 3));
    // Largest length, loop begins at the end, start clamped to length: stops at once.
    send_cmd(make_setup(2, 0, LEN_MAX, LEN_MAX, LEN_MAX, 0, 64, 1'b1, ADDR_MAX));
    // Loop running past the end is cut to one byte, so no loop.
    send_cmd(make_setup(3, 131070, 4, 3, 5, 32'h8000, 33, 1'b1, 1));
    c        = noise_fields();
    c.action = ACT_NONE;
    send_cmd(c);
    repeat (6) send_cmd(render_cmd());
    // Shrink a playing voice without retrigger so it lands past its end.
    send_cmd(make_setup(0, 131068, 2, 0, 0, 32'h10000, 64, 1'b0, 0));
    // Loop length 2 stays unlooped; length 3 loops; zero volume.
    send_cmd(make_setup(1, 131068, 6, 0, 2, 32'h10000, 64, 1'b1, 0));
    send_cmd(make_setup(3, 131068, 6, 1, 3, 32'h2C000, 0, 1'b1, 0));
    repeat (5) send_cmd(render_cmd());
  endtask

  // With the player off, renders give zero and voice state holds still.
  task automatic test_player_disabled();
    send_cmd(make_setup(2, 131068, 6, 0, 6, 32'h6000, 50, 1'b1, 0));
    set_player_enable(1'b0);
    repeat (4) send_cmd(render_cmd());
    send_cmd(shaped_setup());
    repeat (4) send_cmd(render_cmd());
    set_player_enable(1'b1);
    repeat (6) send_cmd(render_cmd());
  endtask

  // Hold the output off for a long stretch while renders keep coming, then pause
  // the sender until everything has drained.
  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (40) send_cmd(render_cmd());
    wait_results_drained();
  endtask

  // Scenes of written regions, voice set-ups and renders under each idling mix.
  task automatic test_random_traffic();
    int unsigned idle_mix  [4] = '{0, 48, 0, 17};
    int unsigned stall_mix [4] = '{0, 0, 48, 17};
    int unsigned items_goal;
    int unsigned roll;
    in_t         c;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      items_goal     = items_sent + 310;
      while (items_sent < items_goal) begin
        if ($urandom_range(99) < 55) write_bytes($urandom_range(ADDR_MAX), $urandom_range(40, 2));
        repeat ($urandom_range(4, 1)) send_cmd(shaped_setup());
        repeat ($urandom_range(24, 6)) begin
          roll = $urandom_range(99);
          if (roll < 86) begin
            send_cmd(render_cmd());
          end else if (roll < 91) begin
            send_cmd(noise_fields());
          end else if (roll < 96) begin
            send_cmd(shaped_setup());
          end else begin
            c        = noise_fields();
            c.action = ACT_NONE;
            send_cmd(c);
          end
        end
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_left      = 0;
    hold_req       = 1'b0;
    mix_enabled    = 1'b0;
    v_on           = '0;
    for (int k = 0; k < 4; k++) begin
      v_base[k] = 0;
      v_len[k]  = 0;
      v_lbeg[k] = 0;
      v_llen[k] = 0;
      v_pos[k]  = 0;
      v_step[k] = 0;
      v_vol[k]  = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_player_enable(1'b1);
    test_wrap_and_extremes();
    test_player_disabled();
    test_output_hold_off();
    test_random_traffic();

    // Drain, then give any stray transfer time to show up.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
